@@ rtl/ddo_pkg.sv @@
// Shared types, constants and arithmetic helpers for the odometry and go-to-goal block.
package ddo_pkg;

	typedef struct packed {
		logic signed [15:0] count_left;
		logic signed [15:0] count_right;
	} ddo_in_t;

	typedef struct packed {
		logic signed [15:0] speed_left;
		logic signed [15:0] speed_right;
		logic signed [15:0] goal_speed_left;
		logic signed [15:0] goal_speed_right;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_heading;
		logic               arrived;
	} ddo_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic vec;
	} ddo_cordic_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MDH, ST_MTR, ST_ANG, ST_MOD, ST_FOLD1, ST_FOLD2, ST_ROT, ST_CS,
		ST_MX0, ST_MX1, ST_MY0, ST_MY1, ST_MY2, ST_UY, ST_VEC0, ST_VEC1, ST_VEC,
		ST_MD, ST_DT, ST_MDT, ST_MHT, ST_OUT
	} ddo_state_t;

	typedef enum logic [3:0] {
		MS_NONE, MS_DIFF, MS_SUM, MS_CLO, MS_CHI, MS_SLO, MS_SHI, MS_MAG, MS_DIST, MS_ETH
	} ddo_mul_sel_t;

	localparam logic [2:0] CFG_TARGET_X         = 3'd0;
	localparam logic [2:0] CFG_TARGET_Y         = 3'd1;
	localparam logic [2:0] CFG_GAIN_DISTANCE    = 3'd2;
	localparam logic [2:0] CFG_GAIN_HEADING     = 3'd3;
	localparam logic [2:0] CFG_ARRIVE_MARGIN    = 3'd4;
	localparam logic [2:0] CFG_HALF_CM_PER_TICK = 3'd5;
	localparam logic [2:0] CFG_RAD_PER_TICK     = 3'd6;

	localparam logic signed [47:0] Q30_PI       = 48'sd3373259426;
	localparam logic signed [47:0] Q30_HALF_PI  = 48'sd1686629713;
	localparam logic signed [47:0] Q30_TWO_PI   = 48'sd6746518852;
	localparam logic signed [47:0] Q30_INV_GAIN = 48'sd652032874;
	localparam logic signed [47:0] Q24_INV_GAIN = 48'sd10188014;

	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] r;
		case (i)
			5'd0: r = 31'd843314857;
			5'd1: r = 31'd497837829;
			5'd2: r = 31'd263043837;
			5'd3: r = 31'd133525159;
			5'd4: r = 31'd67021687;
			5'd5: r = 31'd33543516;
			5'd6: r = 31'd16775851;
			5'd7: r = 31'd8388437;
			5'd8: r = 31'd4194283;
			5'd9: r = 31'd2097149;
			5'd31: r = 31'd0;
			default: r = 31'd1 << (5'd30 - i);
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
		logic signed [15:0] r;
		if (v > 66'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -66'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	function automatic logic signed [65:0] trunc24(input logic signed [65:0] v);
		logic signed [65:0] b;
		b = v[65] ? 66'sd16777215 : 66'sd0;
		return (v + b) >>> 24;
	endfunction

endpackage

@@ rtl/ddo_mul.sv @@
// Shared registered multiplier for all products of the block.
module ddo_mul import ddo_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [35:0] a,
	input  logic signed [24:0] b,
	output logic signed [60:0] p_q
);

	logic signed [60:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod;
		end
	end

endmodule

@@ rtl/ddo_cordic.sv @@
// Shared CORDIC stage: one rotation or vectoring step per cycle while step is set.
module ddo_cordic import ddo_pkg::*; (
	input  logic               clk,
	input  ddo_cordic_ctl_t    ctl,
	input  logic [4:0]         it,
	input  logic signed [35:0] ld_x,
	input  logic signed [35:0] ld_y,
	input  logic signed [33:0] ld_z,
	output logic signed [35:0] x_q,
	output logic signed [35:0] y_q,
	output logic signed [33:0] z_q,
	output logic               y_zero
);

	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [33:0] at;
	logic               dpos;

	assign xs = x_q >>> it;
	assign ys = y_q >>> it;
	assign at = $signed({3'b000, atan_q30(it)});
	assign dpos = ctl.vec ? y_q[35] : !z_q[33];
	assign y_zero = (y_q == 36'sd0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= ld_x;
			y_q <= ld_y;
			z_q <= ld_z;
		end else if (ctl.step) begin
			if (dpos) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

endmodule

@@ rtl/diff_drive_odometry_goto_point_core.sv @@
// Top level: odometry update and go-to-goal steering under a step sequencer.
//
//  Channel | Signals                         | Direction | Payload
//  cmd     | cmd_valid, cmd_ready, cmd       | in        | ddo_in_t
//  res     | res_valid, res_ready, res       | out       | ddo_out_t
//  cfg     | cfg_we, cfg_index, cfg_data     | in        | register write
//
// Each request runs through the 14-step angle reduction and two passes of the shared
// CORDIC stage before its result is loaded; no new request is taken until the sequencer
// is back in idle. The vectoring pass ends early when its y error reaches zero.
// The result waits in an output register; a stalled result holds the sequencer in its
// last step. Reset clears the pose, the last counts and all configuration registers.
module diff_drive_odometry_goto_point_core import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  ddo_in_t     cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output ddo_out_t    res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam logic [4:0] LAST = 5'(NSTEPS - 1);

	ddo_state_t state_q, state_d;
	ddo_mul_sel_t mul_sel;
	logic mul_en;
	ddo_cordic_ctl_t cctl;

	logic signed [31:0] tx_q, ty_q;
	logic [15:0] gd_q, gh_q;
	logic [23:0] margin_q, hcpt_q, rpt_q;

	logic [15:0] last_l_q, last_r_q;
	logic signed [15:0] sl_q, sr_q;
	logic signed [31:0] rx_q, ry_q, head_q, newh_q;
	logic signed [35:0] travel_q;
	logic [46:0] red_q;
	logic angneg_q;
	logic [3:0] k_q;
	logic signed [34:0] rr_q;
	logic rneg_q;
	logic [4:0] it_q;
	logic signed [31:0] c_q, s_q;
	logic signed [65:0] acc_q;
	logic signed [32:0] ex_q, ey_q;
	logic arr_q;
	logic signed [35:0] dist_q, eth_q;
	logic res_valid_q;
	ddo_out_t res_q;

	logic signed [35:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [60:0] prod;
	logic signed [65:0] p66;
	logic signed [65:0] p_rnd8;
	logic signed [16:0] diff17, sum17;
	logic signed [32:0] hsum;
	logic [32:0] habs;
	logic [46:0] cmpv;
	logic [32:0] mres;
	logic signed [34:0] r0;
	logic signed [35:0] ld_x, ld_y;
	logic signed [33:0] ld_z;
	logic signed [35:0] cx, cy, cxc, cyc;
	logic signed [35:0] cor_x, cor_y;
	logic signed [33:0] cor_z;
	logic cor_yzero;
	logic signed [33:0] aex, aey;
	logic signed [33:0] bear;
	logic signed [65:0] dm, dp;
	logic out_load;

	ddo_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	ddo_cordic u_cordic (
		.clk    (clk),
		.ctl    (cctl),
		.it     (it_q),
		.ld_x   (ld_x),
		.ld_y   (ld_y),
		.ld_z   (ld_z),
		.x_q    (cor_x),
		.y_q    (cor_y),
		.z_q    (cor_z),
		.y_zero (cor_yzero)
	);

	assign diff17 = 17'(sr_q) - 17'(sl_q);
	assign sum17 = 17'(sr_q) + 17'(sl_q);
	assign p66 = 66'(prod);
	assign p_rnd8 = (p66 + 66'sd128) >>> 8;
	assign hsum = 33'(head_q) + 33'(newh_q);
	assign habs = hsum[32] ? 33'(-hsum) : 33'(hsum);
	assign cmpv = 47'(Q30_TWO_PI) << k_q;
	assign mres = red_q[32:0];
	assign r0 = (angneg_q && mres != 33'd0) ? 35'(Q30_TWO_PI) - $signed({2'b00, mres})
		: $signed({2'b00, mres});
	assign cx = rneg_q ? -cor_x : cor_x;
	assign cy = rneg_q ? -cor_y : cor_y;
	assign cxc = (cx > 36'sd1073741824) ? 36'sd1073741824
		: ((cx < -36'sd1073741824) ? -36'sd1073741824 : cx);
	assign cyc = (cy > 36'sd1073741824) ? 36'sd1073741824
		: ((cy < -36'sd1073741824) ? -36'sd1073741824 : cy);
	assign aex = ex_q[32] ? -34'(ex_q) : 34'(ex_q);
	assign aey = ey_q[32] ? -34'(ey_q) : 34'(ey_q);
	assign bear = (cor_z + 34'sd8192) >>> 14;
	assign dm = acc_q - p66;
	assign dp = acc_q + p66;
	assign out_load = (state_q == ST_OUT) && (!res_valid_q || res_ready);

	always_comb begin
		case (mul_sel)
			MS_DIFF: begin
				mul_a = 36'(diff17);
				mul_b = $signed({1'b0, rpt_q});
			end
			MS_SUM: begin
				mul_a = 36'(sum17);
				mul_b = $signed({1'b0, hcpt_q});
			end
			MS_CLO: begin
				mul_a = travel_q;
				mul_b = $signed({10'd0, c_q[14:0]});
			end
			MS_CHI: begin
				mul_a = travel_q;
				mul_b = 25'(c_q >>> 15);
			end
			MS_SLO: begin
				mul_a = travel_q;
				mul_b = $signed({10'd0, s_q[14:0]});
			end
			MS_SHI: begin
				mul_a = travel_q;
				mul_b = 25'(s_q >>> 15);
			end
			MS_MAG: begin
				mul_a = cor_x;
				mul_b = 25'(Q24_INV_GAIN);
			end
			MS_DIST: begin
				mul_a = dist_q;
				mul_b = $signed({9'd0, gd_q});
			end
			MS_ETH: begin
				mul_a = eth_q;
				mul_b = $signed({9'd0, gh_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		ld_x = 36'(Q30_INV_GAIN);
		ld_y = '0;
		ld_z = '0;
		if (state_q == ST_VEC1) begin
			if (ex_q[32]) begin
				if (!ey_q[32]) begin
					ld_x = 36'(ey_q);
					ld_y = -36'(ex_q);
					ld_z = 34'(Q30_HALF_PI);
				end else begin
					ld_x = -36'(ey_q);
					ld_y = 36'(ex_q);
					ld_z = -34'(Q30_HALF_PI);
				end
			end else begin
				ld_x = 36'(ex_q);
				ld_y = 36'(ey_q);
			end
		end else begin
			if (rr_q > 35'(Q30_HALF_PI)) begin
				ld_z = 34'(rr_q - 35'(Q30_PI));
			end else if (rr_q < -35'(Q30_HALF_PI)) begin
				ld_z = 34'(rr_q + 35'(Q30_PI));
			end else begin
				ld_z = 34'(rr_q);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (cmd_valid) state_d = ST_MDH;
			ST_MDH:   state_d = ST_MTR;
			ST_MTR:   state_d = ST_ANG;
			ST_ANG:   state_d = ST_MOD;
			ST_MOD:   if (k_q == 4'd0) state_d = ST_FOLD1;
			ST_FOLD1: state_d = ST_FOLD2;
			ST_FOLD2: state_d = ST_ROT;
			ST_ROT:   if (it_q == LAST) state_d = ST_CS;
			ST_CS:    state_d = ST_MX0;
			ST_MX0:   state_d = ST_MX1;
			ST_MX1:   state_d = ST_MY0;
			ST_MY0:   state_d = ST_MY1;
			ST_MY1:   state_d = ST_MY2;
			ST_MY2:   state_d = ST_UY;
			ST_UY:    state_d = ST_VEC0;
			ST_VEC0:  state_d = ST_VEC1;
			ST_VEC1:  state_d = ST_VEC;
			ST_VEC:   if (cor_yzero || it_q == LAST) state_d = ST_MD;
			ST_MD:    state_d = ST_DT;
			ST_DT:    state_d = ST_MDT;
			ST_MDT:   state_d = ST_MHT;
			ST_MHT:   state_d = ST_OUT;
			ST_OUT:   if (!res_valid_q || res_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		mul_en = 1'b0;
		mul_sel = MS_NONE;
		cctl = '0;
		case (state_q)
			ST_IDLE:  cmd_ready = 1'b1;
			ST_MDH: begin
				mul_en = 1'b1;
				mul_sel = MS_DIFF;
			end
			ST_MTR: begin
				mul_en = 1'b1;
				mul_sel = MS_SUM;
			end
			ST_FOLD2: cctl.load = 1'b1;
			ST_ROT:   cctl.step = 1'b1;
			ST_MX0: begin
				mul_en = 1'b1;
				mul_sel = MS_CLO;
			end
			ST_MX1: begin
				mul_en = 1'b1;
				mul_sel = MS_CHI;
			end
			ST_MY0: begin
				mul_en = 1'b1;
				mul_sel = MS_SLO;
			end
			ST_MY1: begin
				mul_en = 1'b1;
				mul_sel = MS_SHI;
			end
			ST_VEC1: begin
				cctl.load = 1'b1;
				cctl.vec = 1'b1;
			end
			ST_VEC: begin
				cctl.step = !cor_yzero;
				cctl.vec = 1'b1;
			end
			ST_MD: begin
				mul_en = 1'b1;
				mul_sel = MS_MAG;
			end
			ST_MDT: begin
				mul_en = 1'b1;
				mul_sel = MS_DIST;
			end
			ST_MHT: begin
				mul_en = 1'b1;
				mul_sel = MS_ETH;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			tx_q <= '0;
			ty_q <= '0;
			gd_q <= '0;
			gh_q <= '0;
			margin_q <= '0;
			hcpt_q <= '0;
			rpt_q <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			head_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_X:         tx_q <= $signed(cfg_data);
					CFG_TARGET_Y:         ty_q <= $signed(cfg_data);
					CFG_GAIN_DISTANCE:    gd_q <= cfg_data[15:0];
					CFG_GAIN_HEADING:     gh_q <= cfg_data[15:0];
					CFG_ARRIVE_MARGIN:    margin_q <= cfg_data[23:0];
					CFG_HALF_CM_PER_TICK: hcpt_q <= cfg_data[23:0];
					CFG_RAD_PER_TICK:     rpt_q <= cfg_data[23:0];
					default:              tx_q <= tx_q;
				endcase
			end
			if (state_q == ST_IDLE && cmd_valid) begin
				last_l_q <= cmd.count_left;
				last_r_q <= cmd.count_right;
			end
			if (state_q == ST_ANG) begin
				head_q <= newh_q;
			end
			if (state_q == ST_MY1) begin
				rx_q <= sat32(66'(rx_q) + ((acc_q + 66'sd536870912) >>> 30));
			end
			if (state_q == ST_UY) begin
				ry_q <= sat32(66'(ry_q) + ((acc_q + 66'sd536870912) >>> 30));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sl_q <= cmd.count_left - $signed(last_l_q);
				sr_q <= cmd.count_right - $signed(last_r_q);
			end
			ST_MTR: newh_q <= sat32(66'(head_q) + p_rnd8);
			ST_ANG: begin
				travel_q <= 36'(p_rnd8);
				red_q <= {1'b0, habs, 13'd0};
				angneg_q <= hsum[32];
				k_q <= 4'd13;
			end
			ST_MOD: begin
				if (red_q >= cmpv) begin
					red_q <= red_q - cmpv;
				end
				k_q <= k_q - 4'd1;
			end
			ST_FOLD1: rr_q <= (r0 > 35'(Q30_PI)) ? r0 - 35'(Q30_TWO_PI) : r0;
			ST_FOLD2: begin
				rneg_q <= (rr_q > 35'(Q30_HALF_PI)) || (rr_q < -35'(Q30_HALF_PI));
				it_q <= '0;
			end
			ST_ROT: it_q <= it_q + 5'd1;
			ST_CS: begin
				c_q <= 32'(cxc);
				s_q <= 32'(cyc);
			end
			ST_MX1: acc_q <= p66;
			ST_MY0: acc_q <= acc_q + (p66 <<< 15);
			ST_MY1: acc_q <= p66;
			ST_MY2: acc_q <= acc_q + (p66 <<< 15);
			ST_VEC0: begin
				ex_q <= 33'(tx_q) - 33'(rx_q);
				ey_q <= 33'(ty_q) - 33'(ry_q);
			end
			ST_VEC1: begin
				arr_q <= (aex <= $signed({10'd0, margin_q}))
					&& (aey <= $signed({10'd0, margin_q}));
				it_q <= '0;
			end
			ST_VEC: it_q <= it_q + 5'd1;
			ST_DT: begin
				dist_q <= 36'((p66 + 66'sd8388608) >>> 24);
				eth_q <= 36'(bear) - 36'(head_q);
			end
			ST_MHT: acc_q <= p66;
			default: begin
				it_q <= it_q;
			end
		endcase
		if (out_load) begin
			res_q.speed_left <= sl_q;
			res_q.speed_right <= sr_q;
			res_q.goal_speed_left <= sat16(trunc24(dm));
			res_q.goal_speed_right <= sat16(trunc24(dp));
			res_q.pose_x <= rx_q;
			res_q.pose_y <= ry_q;
			res_q.pose_heading <= head_q;
			res_q.arrived <= arr_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

@@ rtl/ddo_checker.sv @@
// Port-level checker for the odometry block, bound to the top level.
module ddo_checker import ddo_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input logic     res_valid,
	input logic     res_ready,
	input ddo_out_t res
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("Block took a request while busy.");

	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!cmd_ready))
		else $error("Result appeared without a request in progress.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Stalled result changed.");

endmodule

bind diff_drive_odometry_goto_point_core ddo_checker u_ddo_checker (.*);
